/* design/dsg_pkg.sv */
// dsg_pkg: shared constants, types and the quarter-wave sine table
// for the decaying sine generator; no dependencies
package dsg_pkg;

  // sizes
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int COUNT_WIDTH      = 24;
  // table depth rounded down to a power of two
  localparam int SineBits  = $clog2(SINE_TABLE_DEPTH + 1) - 1;
  localparam int SineDepth = 1 << SineBits;
  localparam int SineAddrW = SineBits + 1;

  localparam int PhaseW  = 32;
  localparam int AmpW    = 16;
  localparam int DecayW  = 31;
  localparam int EnvW    = 32;
  localparam int SampleW = 16;
  localparam int PeakW   = 15;
  localparam int CfgIdxW = 8;
  localparam int CfgDataW = 32;
  localparam int MulW    = 32;
  localparam int ProdW   = 2 * MulW;

  // reset values
  localparam logic [AmpW-1:0]        AmpReset   = 16'd32767;
  localparam logic [DecayW-1:0]      DecayReset = 31'h7FFF_FFFF;
  localparam logic [COUNT_WIDTH-1:0] CountReset = 24'd44100;
  localparam logic [EnvW-1:0]        EnvOne     = 32'h8000_0000;
  localparam logic [PeakW-1:0]       MagMax     = 15'h7FFF;

  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;

  // register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_PHASE_STEP   = 8'd0,
    REG_AMPLITUDE    = 8'd1,
    REG_DECAY_FACTOR = 8'd2,
    REG_SAMPLE_COUNT = 8'd3
  } dsg_reg_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_MUL_AMP,
    ST_MUL_ENV,
    ST_SCALE,
    ST_FINISH
  } dsg_state_t;

  // multiplier operand select
  typedef enum logic [1:0] {
    MUL_SINE_AMP,
    MUL_PROD_ENV,
    MUL_ENV_DECAY
  } dsg_mul_sel_t;

  typedef logic [SineDepth:0][SampleW-1:0] sine_rom_t;

  // quarter-wave table, round(32767 * sin(pi/2 * k / D)), Taylor series to x^11
  function automatic sine_rom_t build_sine();
    sine_rom_t  rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] v;
    for (int k = 0; k <= SineDepth; k++) begin
      x  = (HalfPiQ30 * 64'(k)) / SineDepth;
      x2 = (x * x) >> 30;
      s  = x;
      t  = ((x * x2) >> 30) / 64'd6;
      s  = s - t;
      t  = ((t * x2) >> 30) / 64'd20;
      s  = s + t;
      t  = ((t * x2) >> 30) / 64'd42;
      s  = s - t;
      t  = ((t * x2) >> 30) / 64'd72;
      s  = s + t;
      t  = ((t * x2) >> 30) / 64'd110;
      s  = s - t;
      v  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
      if (v > 64'd32767) begin
        v = 64'd32767;
      end
      rom[k] = v[SampleW-1:0];
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine();

endpackage

/* design/dsg_if.sv */
// dsg_if: valid/ready channel interfaces for sample ticks, results and
// register writes; depends on dsg_pkg
interface dsg_in_if;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface dsg_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [dsg_pkg::SampleW-1:0]   sample;
  logic [dsg_pkg::COUNT_WIDTH-1:0]      sample_index;
  logic [dsg_pkg::PeakW-1:0]            peak_magnitude;
  logic [dsg_pkg::COUNT_WIDTH-1:0]      peak_index;
  logic                                 done_res;
  modport source (output valid, output sample, output sample_index,
                  output peak_magnitude, output peak_index, output done_res,
                  input ready);
  modport sink   (input valid, input sample, input sample_index,
                  input peak_magnitude, input peak_index, input done_res,
                  output ready);
endinterface

interface dsg_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [dsg_pkg::CfgIdxW-1:0]   index;
  logic [dsg_pkg::CfgDataW-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* design/dsg_sine_rom.sv */
// dsg_sine_rom: quarter-wave sine lookup with registered read data
// depends on dsg_pkg (SINE_ROM table)
module dsg_sine_rom (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [dsg_pkg::SineAddrW-1:0] rd_addr,
  output logic [dsg_pkg::SampleW-1:0]   rd_data
);
  import dsg_pkg::*;

  logic [SampleW-1:0] rd_data_r;

  // registered read port on the constant table
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= SINE_ROM[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* design/decaying_sine_generator.sv */
// decaying_sine_generator: damped sine oscillator top level, sequencer and
// shared 32x32 multiplier; depends on dsg_pkg, dsg_if and dsg_sine_rom
//
//  channel  dir  handshake     word contents
//  in_if    in   valid/ready   restart
//  out_if   out  valid/ready   sample, sample_index, peak_magnitude,
//                              peak_index, done_res
//  cfg_if   in   valid/ready   index, data (ready always high)
//
// A tick goes from accept to result as accept, table read, three passes
// through the one shared multiplier and commit; a done tick skips the
// multiplier passes. The passes are sine*amplitude, *envelope, then
// envelope*decay. in_if.ready is high only while the sequencer is idle.
// rst_n is synchronous, active low. A result waits in the output register;
// the next tick is accepted meanwhile and stalls at commit only if the
// previous word is still not taken.
module decaying_sine_generator (
  input  logic      clk,
  input  logic      rst_n,
  dsg_in_if.sink    in_if,
  dsg_out_if.source out_if,
  dsg_cfg_if.sink   cfg_if
);
  import dsg_pkg::*;

  dsg_state_t state_r, state_nxt;

  // configuration
  logic [PhaseW-1:0]      phase_step_r;
  logic [AmpW-1:0]        amplitude_r;
  logic [DecayW-1:0]      decay_r;
  logic [COUNT_WIDTH-1:0] count_r;

  // tone state
  logic [PhaseW-1:0]      phase_r;
  logic [EnvW-1:0]        env_r;
  logic [COUNT_WIDTH-1:0] frame_r;
  logic [PeakW-1:0]       peak_r;
  logic [COUNT_WIDTH-1:0] peak_frame_r;

  // per tick working values
  logic                   neg_r;
  logic                   done_r;
  logic [PeakW-1:0]       mag_r;
  logic [ProdW-1:0]       prod_r;

  // output register
  logic                   out_valid_r;
  logic [SampleW-1:0]     out_sample_r;
  logic [COUNT_WIDTH-1:0] out_index_r;
  logic [PeakW-1:0]       out_peak_r;
  logic [COUNT_WIDTH-1:0] out_peak_idx_r;
  logic                   out_done_r;

  // control
  logic                   in_fire;
  logic                   commit;
  logic                   rom_en;
  logic                   mul_en;
  dsg_mul_sel_t           mul_sel;
  logic [MulW-1:0]        mul_a;
  logic [MulW-1:0]        mul_b;
  logic [SineAddrW-1:0]   rom_addr;
  logic [SampleW-1:0]     rom_data;
  logic [SineBits-1:0]    tab_idx;
  logic [17:0]            mag_wide;
  logic [PeakW-1:0]       mag_sat;
  logic                   is_done;

  assign in_fire = in_if.valid && in_if.ready;
  assign commit  = (state_r == ST_FINISH) && (!out_valid_r || out_if.ready);
  assign is_done = (frame_r >= count_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:    if (in_fire) state_nxt = ST_LOOKUP;
      ST_LOOKUP:  state_nxt = is_done ? ST_FINISH : ST_MUL_AMP;
      ST_MUL_AMP: state_nxt = ST_MUL_ENV;
      ST_MUL_ENV: state_nxt = ST_SCALE;
      ST_SCALE:   state_nxt = ST_FINISH;
      ST_FINISH:  if (commit) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_if.ready = 1'b0;
    rom_en      = 1'b0;
    mul_en      = 1'b0;
    mul_sel     = MUL_SINE_AMP;
    case (state_r)
      ST_IDLE:    in_if.ready = 1'b1;
      ST_LOOKUP:  rom_en = 1'b1;
      ST_MUL_AMP: begin
        mul_en  = 1'b1;
        mul_sel = MUL_SINE_AMP;
      end
      ST_MUL_ENV: begin
        mul_en  = 1'b1;
        mul_sel = MUL_PROD_ENV;
      end
      ST_SCALE: begin
        mul_en  = 1'b1;
        mul_sel = MUL_ENV_DECAY;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // register writes
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r <= '0;
      amplitude_r  <= AmpReset;
      decay_r      <= DecayReset;
      count_r      <= CountReset;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        REG_PHASE_STEP:   phase_step_r <= cfg_if.data[PhaseW-1:0];
        REG_AMPLITUDE:    amplitude_r  <= cfg_if.data[AmpW-1:0];
        REG_DECAY_FACTOR: decay_r      <= cfg_if.data[DecayW-1:0];
        REG_SAMPLE_COUNT: count_r      <= cfg_if.data[COUNT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // quadrant folding into the table address
  assign tab_idx  = phase_r[PhaseW-3 -: SineBits];
  assign rom_addr = phase_r[PhaseW-2]
                  ? SineAddrW'(SineDepth) - {1'b0, tab_idx}
                  : {1'b0, tab_idx};

  dsg_sine_rom u_rom (
    .clk     (clk),
    .rd_en   (rom_en),
    .rd_addr (rom_addr),
    .rd_data (rom_data)
  );

  // shared multiplier operands
  always_comb begin
    case (mul_sel)
      MUL_SINE_AMP: begin
        mul_a = {{(MulW-SampleW){1'b0}}, rom_data};
        mul_b = {{(MulW-AmpW){1'b0}}, amplitude_r};
      end
      MUL_PROD_ENV: begin
        mul_a = {1'b0, prod_r[MulW-2:0]};
        mul_b = env_r;
      end
      MUL_ENV_DECAY: begin
        mul_a = env_r;
        mul_b = {{(MulW-DecayW){1'b0}}, decay_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mul_en) prod_r <= mul_a * mul_b;
  end

  // magnitude from the full product, saturated
  assign mag_wide = prod_r[ProdW-1:46];
  assign mag_sat  = (mag_wide > 18'(MagMax)) ? MagMax : mag_wide[PeakW-1:0];

  // tone state and per tick values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= '0;
      env_r        <= EnvOne;
      frame_r      <= '0;
      peak_r       <= '0;
      peak_frame_r <= '0;
    end else begin
      if (in_fire && in_if.restart) begin
        phase_r      <= '0;
        env_r        <= EnvOne;
        frame_r      <= '0;
        peak_r       <= '0;
        peak_frame_r <= '0;
      end
      if (state_r == ST_SCALE && mag_sat > peak_r) begin
        peak_r       <= mag_sat;
        peak_frame_r <= frame_r;
      end
      if (commit && !done_r) begin
        phase_r <= phase_r + phase_step_r;
        env_r   <= prod_r[EnvW+30:31];
        frame_r <= frame_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_LOOKUP) begin
      neg_r  <= phase_r[PhaseW-1];
      done_r <= is_done;
      mag_r  <= '0;
    end
    if (state_r == ST_SCALE) mag_r <= mag_sat;
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_sample_r   <= neg_r ? -{1'b0, mag_r} : {1'b0, mag_r};
      out_index_r    <= frame_r;
      out_peak_r     <= peak_r;
      out_peak_idx_r <= peak_frame_r;
      out_done_r     <= done_r;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.sample         = out_sample_r;
  assign out_if.sample_index   = out_index_r;
  assign out_if.peak_magnitude = out_peak_r;
  assign out_if.peak_index     = out_peak_idx_r;
  assign out_if.done_res       = out_done_r;

  // a done word carries a zero sample
  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.done_res |-> out_if.sample == '0)
    else $error("done word with nonzero sample");

  // the running peak covers the sample that goes with it
  a_peak_covers: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && !out_if.sample[SampleW-1] |->
      out_if.sample[PeakW-1:0] <= out_if.peak_magnitude)
    else $error("sample above peak magnitude");

  // an accepted tick starts with the table read
  a_accept_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == ST_LOOKUP)
    else $error("tick accepted without lookup");

  // the frame counter moves only on restart or at commit
  a_frame_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire && !commit |=> $stable(frame_r))
    else $error("frame counter moved outside commit");

endmodule

/* bench/decaying_sine_generator_test.sv */
`timescale 1ns / 100ps
// decaying_sine_generator_test: self-checking bench for the damped sine oscillator,
// directed table then randomized tone settings, checked against a local predictor
// depends on dsg_pkg, dsg_if and decaying_sine_generator
module decaying_sine_generator_test;
  import dsg_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 9;
  localparam int TOTAL_TICKS    = 1550;
  localparam int IDLE_SETTLE    = 4;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 12;
  localparam int TIMEOUT_CYCLES = 1000000;

  // register indexes past the end of the map, and the index used on tick rows
  localparam logic [CfgIdxW-1:0] REG_SPARE_FIRST = 8'd4;
  localparam logic [CfgIdxW-1:0] REG_SPARE_LAST  = 8'hFF;
  localparam logic [CfgIdxW-1:0] NO_REG          = '0;

  // one output word of the block
  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic [COUNT_WIDTH-1:0]    sample_index;
    logic [PeakW-1:0]          peak_magnitude;
    logic [COUNT_WIDTH-1:0]    peak_index;
    logic                      done_res;
  } tone_word_t;

  localparam tone_word_t NO_WORD = '0;

  typedef enum logic [1:0] {ROW_WRITE, ROW_TICK, ROW_TICK_KNOWN} row_kind_t;

  typedef struct packed {
    row_kind_t           kind;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
    logic                restart;
    tone_word_t          word;
  } plan_row_t;

  // directed sequence: quarter-turn step with saturating gain walks all quadrants,
  // peak tie, done and its repeat, zero count, dead envelope, spare indexes
  localparam int PLAN_LEN = 30;
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    '{ROW_TICK_KNOWN, NO_REG, 32'd0, 1'b0, '{16'sd0, 24'd0, 15'd0, 24'd0, 1'b0}},
    '{ROW_WRITE, REG_PHASE_STEP, 32'h4000_0000, 1'b0, NO_WORD},
    '{ROW_WRITE, REG_AMPLITUDE, 32'd65535, 1'b0, NO_WORD},
    '{ROW_WRITE, REG_SAMPLE_COUNT, 32'd5, 1'b0, NO_WORD},
    '{ROW_TICK_KNOWN, NO_REG, 32'd0, 1'b1, '{16'sd0, 24'd0, 15'd0, 24'd0, 1'b0}},
    '{ROW_TICK_KNOWN, NO_REG, 32'd0, 1'b0, '{16'sd32767, 24'd1, 15'd32767, 24'd1, 1'b0}},
    '{ROW_TICK_KNOWN, NO_REG, 32'd0, 1'b0, '{16'sd0, 24'd2, 15'd32767, 24'd1, 1'b0}},
    '{ROW_TICK_KNOWN, NO_REG, 32'd0, 1'b0, '{-16'sd32767, 24'd3, 15'd32767, 24'd1, 1'b0}},
    '{ROW_TICK_KNOWN, NO_REG, 32'd0, 1'b0, '{16'sd0, 24'd4, 15'd32767, 24'd1, 1'b0}},
    '{ROW_TICK_KNOWN, NO_REG, 32'd0, 1'b0, '{16'sd0, 24'd5, 15'd32767, 24'd1, 1'b1}},
    '{ROW_TICK_KNOWN, NO_REG, 32'd0, 1'b0, '{16'sd0, 24'd5, 15'd32767, 24'd1, 1'b1}},
    '{ROW_WRITE, REG_SAMPLE_COUNT, 32'd0, 1'b0, NO_WORD},
    '{ROW_TICK_KNOWN, NO_REG, 32'd0, 1'b1, '{16'sd0, 24'd0, 15'd0, 24'd0, 1'b1}},
    '{ROW_WRITE, REG_SAMPLE_COUNT, 32'h00FF_FFFF, 1'b0, NO_WORD},
    '{ROW_WRITE, REG_PHASE_STEP, 32'hFFFF_FFFF, 1'b0, NO_WORD},
    '{ROW_WRITE, REG_DECAY_FACTOR, 32'd0, 1'b0, NO_WORD},
    '{ROW_TICK, NO_REG, 32'd0, 1'b1, NO_WORD},
    '{ROW_TICK, NO_REG, 32'd0, 1'b0, NO_WORD},
    '{ROW_TICK, NO_REG, 32'd0, 1'b0, NO_WORD},
    '{ROW_WRITE, REG_DECAY_FACTOR, 32'h7FFF_FFFF, 1'b0, NO_WORD},
    '{ROW_WRITE, REG_SPARE_FIRST, 32'hFFFF_FFFF, 1'b0, NO_WORD},
    '{ROW_WRITE, REG_SPARE_LAST, 32'h1234_5678, 1'b0, NO_WORD},
    '{ROW_WRITE, REG_AMPLITUDE, 32'hFFFF_8000, 1'b0, NO_WORD},
    '{ROW_WRITE, REG_PHASE_STEP, 32'h0123_4567, 1'b0, NO_WORD},
    '{ROW_TICK, NO_REG, 32'd0, 1'b1, NO_WORD},
    '{ROW_TICK, NO_REG, 32'd0, 1'b0, NO_WORD},
    '{ROW_TICK, NO_REG, 32'd0, 1'b0, NO_WORD},
    '{ROW_WRITE, REG_AMPLITUDE, 32'd0, 1'b0, NO_WORD},
    '{ROW_TICK, NO_REG, 32'd0, 1'b0, NO_WORD},
    '{ROW_TICK, NO_REG, 32'd0, 1'b1, NO_WORD}
  };

  logic clk = 1'b0;
  logic rst_n;

  dsg_in_if  tick_ch ();
  dsg_out_if tone_ch ();
  dsg_cfg_if reg_ch ();

  decaying_sine_generator dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (tick_ch),
    .out_if (tone_ch),
    .cfg_if (reg_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // predictor copy of registers and tone state
  logic [PhaseW-1:0]      cfg_step;
  logic [AmpW-1:0]        cfg_amp;
  logic [DecayW-1:0]      cfg_decay;
  logic [COUNT_WIDTH-1:0] cfg_count;
  logic [PhaseW-1:0]      tone_phase;
  logic [EnvW-1:0]        tone_env;
  logic [COUNT_WIDTH-1:0] tone_frame;
  logic [PeakW-1:0]       tone_peak;
  logic [COUNT_WIDTH-1:0] tone_peak_frame;
  logic [SampleW-1:0]     quarter_sine [0:4096];
  int                     tab_bits;
  int                     tab_depth;

  tone_word_t tone_q [$];

  // bench status shared between processes
  bit steady;
  int squeeze_asked;
  int mismatches;
  int ticks_sent;
  int restarts_sent;
  int words_seen;
  int done_seen;
  int regs_written;
  int settings_run;

  // quarter-wave table, Q30 Taylor series to the x^11 term
  function automatic void fill_quarter_sine();
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] acc;
    logic [63:0] v;
    tab_depth = 1;
    tab_bits  = 0;
    while (tab_bits < 12 && (tab_depth << 1) <= SINE_TABLE_DEPTH) begin
      tab_depth = tab_depth << 1;
      tab_bits++;
    end
    for (int k = 0; k <= tab_depth; k++) begin
      x    = (64'd1686629713 * 64'(k)) / 64'(tab_depth);
      x2   = (x * x) >> 30;
      term = x;
      acc  = x;
      for (int n = 1; n <= 5; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) acc = acc - term;
        else acc = acc + term;
      end
      v = (acc * 64'd32767 + (64'd1 << 29)) >> 30;
      if (v > 64'd32767) v = 64'd32767;
      quarter_sine[k] = v[SampleW-1:0];
    end
  endfunction

  function automatic void clear_tone();
    tone_phase      = '0;
    tone_env        = 32'h8000_0000;
    tone_frame      = '0;
    tone_peak       = '0;
    tone_peak_frame = '0;
  endfunction

  // one sample tick of the oscillator
  function automatic tone_word_t tone_tick(input logic restart);
    tone_word_t  w;
    logic [63:0] prod;
    int          idx;
    int          level;
    logic [SampleW-1:0] mag;
    if (restart) clear_tone();
    w.sample_index = tone_frame;
    w.done_res     = 1'b0;
    // tone finished: zero word, nothing moves
    if (tone_frame >= cfg_count) begin
      w.sample         = '0;
      w.peak_magnitude = tone_peak;
      w.peak_index     = tone_peak_frame;
      w.done_res       = 1'b1;
      return w;
    end
    // quadrant from the top phase bits, mirrored read in odd quadrants
    idx  = int'(tone_phase[29:0] >> (30 - tab_bits));
    mag  = tone_phase[30] ? quarter_sine[tab_depth - idx] : quarter_sine[idx];
    prod = (64'(mag) * 64'(cfg_amp) * 64'(tone_env)) >> 46;
    if (prod > 64'd32767) prod = 64'd32767;
    level    = tone_phase[31] ? -int'(prod) : int'(prod);
    w.sample = level[SampleW-1:0];
    // ties keep the earlier frame
    if (prod[PeakW-1:0] > tone_peak) begin
      tone_peak       = prod[PeakW-1:0];
      tone_peak_frame = tone_frame;
    end
    w.peak_magnitude = tone_peak;
    w.peak_index     = tone_peak_frame;
    tone_phase = tone_phase + cfg_step;
    tone_env   = 32'((64'(tone_env) * 64'(cfg_decay)) >> 31);
    tone_frame = tone_frame + 1'b1;
    return w;
  endfunction

  // random junk above the register width, half of the time
  function automatic logic [CfgDataW-1:0] pad_high(input logic [CfgDataW-1:0] v, input int w);
    logic [CfgDataW-1:0] keep;
    keep = (CfgDataW'(1) << w) - 1;
    if ($urandom_range(0, 1) == 1) return (v & keep) | ($urandom() & ~keep);
    return v & keep;
  endfunction

  // offer one tick word and record its prediction once taken
  task automatic send_tick(input logic restart, input logic typed, input tone_word_t word);
    tone_word_t predicted;
    tick_ch.valid   <= 1'b1;
    tick_ch.restart <= restart;
    do @(posedge clk); while (!tick_ch.ready);
    predicted = tone_tick(restart);
    tone_q.push_back(typed ? word : predicted);
    ticks_sent++;
    if (restart) restarts_sent++;
  endtask

  // sender gap: mostly none or short, now and then long
  task automatic pause_sender();
    int pick;
    int gap;
    pick = $urandom_range(0, 99);
    if (steady || pick < 55) gap = 0;
    else if (pick < 90) gap = $urandom_range(1, 3);
    else if (pick < 98) gap = $urandom_range(4, 12);
    else gap = $urandom_range(20, 60);
    if (gap > 0) begin
      tick_ch.valid   <= 1'b0;
      tick_ch.restart <= 1'($urandom_range(0, 1));
      repeat (gap) @(posedge clk);
    end
  endtask

  // register write, only once every pending word has drained
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    tick_ch.valid <= 1'b0;
    while (tone_q.size() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
    reg_ch.valid <= 1'b1;
    reg_ch.index <= idx;
    reg_ch.data  <= data;
    do @(posedge clk); while (!reg_ch.ready);
    reg_ch.valid <= 1'b0;
    regs_written++;
    case (idx)
      REG_PHASE_STEP:   cfg_step  = data[PhaseW-1:0];
      REG_AMPLITUDE:    cfg_amp   = data[AmpW-1:0];
      REG_DECAY_FACTOR: cfg_decay = data[DecayW-1:0];
      REG_SAMPLE_COUNT: cfg_count = data[COUNT_WIDTH-1:0];
      default: ;
    endcase
  endtask

  // compare a taken word with the oldest prediction
  task automatic check_word();
    tone_word_t got;
    tone_word_t want;
    got = '{tone_ch.sample, tone_ch.sample_index, tone_ch.peak_magnitude,
            tone_ch.peak_index, tone_ch.done_res};
    words_seen++;
    if (got.done_res) done_seen++;
    if (tone_q.size() == 0) begin
      $display("%0t: word with nothing pending, got %p", $time, got);
      mismatches++;
      return;
    end
    want = tone_q.pop_front();
    if (got.sample !== want.sample) begin
      $display("%0t: sample expected %0d, got %0d", $time, want.sample, got.sample);
      mismatches++;
    end
    if (got.sample_index !== want.sample_index) begin
      $display("%0t: sample_index expected %0d, got %0d", $time, want.sample_index,
               got.sample_index);
      mismatches++;
    end
    if (got.peak_magnitude !== want.peak_magnitude) begin
      $display("%0t: peak_magnitude expected %0d, got %0d", $time, want.peak_magnitude,
               got.peak_magnitude);
      mismatches++;
    end
    if (got.peak_index !== want.peak_index) begin
      $display("%0t: peak_index expected %0d, got %0d", $time, want.peak_index,
               got.peak_index);
      mismatches++;
    end
    if (got.done_res !== want.done_res) begin
      $display("%0t: done_res expected %0d, got %0d", $time, want.done_res, got.done_res);
      mismatches++;
    end
  endtask

  // result side: checks words and throttles ready
  initial begin : tone_sink
    int stall_left;
    int served;
    int pick;
    stall_left = 0;
    served     = 0;
    tone_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (tone_ch.valid && tone_ch.ready) check_word();
      // long hold-off on request, otherwise occasional short stalls
      if (served != squeeze_asked) begin
        served     = squeeze_asked;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && !steady && $urandom_range(0, 99) < 20) begin
        pick = $urandom_range(0, 99);
        if (pick < 80) stall_left = $urandom_range(1, 3);
        else if (pick < 97) stall_left = $urandom_range(4, 10);
        else stall_left = $urandom_range(15, 40);
      end
      if (stall_left > 0) begin
        tone_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        tone_ch.ready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  // stimulus: reset, directed table, then random tone settings
  initial begin : tick_source
    int phase_len;
    int restart_pct;
    int pick;
    logic [CfgDataW-1:0] value;
    tick_ch.valid   <= 1'b0;
    tick_ch.restart <= 1'b0;
    reg_ch.valid    <= 1'b0;
    reg_ch.index    <= '0;
    reg_ch.data     <= '0;
    rst_n           <= 1'b0;
    steady        = 1'b0;
    squeeze_asked = 0;
    fill_quarter_sine();
    cfg_step  = '0;
    cfg_amp   = 16'd32767;
    cfg_decay = 31'h7FFF_FFFF;
    cfg_count = 24'd44100;
    clear_tone();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // directed part
    for (int i = 0; i < PLAN_LEN; i++) begin
      if (PLAN[i].kind == ROW_WRITE) begin
        write_reg(PLAN[i].idx, PLAN[i].data);
      end else begin
        send_tick(PLAN[i].restart, PLAN[i].kind == ROW_TICK_KNOWN, PLAN[i].word);
        pause_sender();
      end
    end

    // random part: one tone setting per pass
    while (ticks_sent < TOTAL_TICKS) begin
      settings_run++;
      steady      = ($urandom_range(0, 3) == 0);
      restart_pct = ($urandom_range(0, 7) == 0) ? 40 : 3;

      pick = $urandom_range(0, 5);
      case (pick)
        0: value = '0;
        1: value = 32'hFFFF_FFFF;
        2: value = $urandom_range(0, 32'h0400_0000);
        3: value = {10'($urandom()), 22'd0};
        default: value = $urandom();
      endcase
      write_reg(REG_PHASE_STEP, value);

      pick = $urandom_range(0, 7);
      case (pick)
        0: value = 32'd0;
        1: value = 32'd65535;
        2: value = 32'd32768;
        3: value = 32'd32767;
        default: value = $urandom_range(0, 65535);
      endcase
      write_reg(REG_AMPLITUDE, pad_high(value, AmpW));

      // mostly close to one so the tone lives a while
      pick = $urandom_range(0, 9);
      case (pick)
        0: value = 32'd0;
        1: value = 32'h7FFF_FFFF;
        2: value = $urandom_range(0, 32'h7FFF_FFFF);
        3: value = 32'h7FFF_FFFF - $urandom_range(0, 32'h0100_0000);
        default: value = 32'h7FFF_FFFF - $urandom_range(0, 32'h0010_0000);
      endcase
      write_reg(REG_DECAY_FACTOR, pad_high(value, DecayW));

      pick = $urandom_range(0, 9);
      case (pick)
        0: value = 32'd1;
        1: value = 32'h00FF_FFFF;
        2: value = $urandom_range(200, 5000);
        default: value = $urandom_range(2, 120);
      endcase
      write_reg(REG_SAMPLE_COUNT, pad_high(value, COUNT_WIDTH));

      if ($urandom_range(0, 3) == 0) begin
        write_reg($urandom_range(0, 1) ? REG_SPARE_FIRST : REG_SPARE_LAST, $urandom());
      end

      phase_len = $urandom_range(40, 160);
      for (int n = 0; n < phase_len && ticks_sent < TOTAL_TICKS; n++) begin
        // hold the result side off while ticks keep coming
        if ((settings_run == 3 || settings_run == 8) && n == 5) squeeze_asked++;
        send_tick((n == 0 && $urandom_range(0, 9) != 0) ||
                  $urandom_range(0, 99) < restart_pct, 1'b0, NO_WORD);
        pause_sender();
      end
    end

    // drain and finish
    steady = 1'b0;
    tick_ch.valid <= 1'b0;
    while (tone_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d ticks (%0d restarts), %0d words checked, %0d done words",
             ticks_sent, restarts_sent, words_seen, done_seen);
    $display("over %0d random tone settings and %0d register writes",
             settings_run, regs_written);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("%0t: timed out with %0d words pending", $time, tone_q.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
